// ----- design/arpc_pkg.sv -----
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int TABLE_ENTRIES = 32;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_req;

    typedef struct packed {
        logic        done;
        logic        hit;
        logic [47:0] mac;
        logic        stored;
    } t_res;

endpackage

// ----- design/arp_cache_table.sv -----
`timescale 1ns / 1ps
// ARP cache: maps IPv4 addresses to MAC addresses in a fully associative table.
// Input stream: tuser carries the operation (add or lookup), tdata carries the
// address and, for an add, the MAC to store. Output stream: one word per input
// word with the hit flag, the found MAC and the stored flag.
// Entries live in a row of cells. An accepted word launches a probe token into
// the first cell, and the token moves one cell per cycle until a cell holds the
// address or is still free, or it falls off the end of a full table.
// The result is registered once the token stops in a cell or falls off the end
// of the table. One word is in the table at a time, and the input opens again in
// the same cycle that the result is registered.
// A new word is accepted while a finished result still waits at the output.
// When the receiver stalls with a result pending, the token holds its place and
// the table does not change until the pending word is taken.
// Reset clears every valid mark, so the table starts empty and ready at once.
module arp_cache_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,  // key_ip[31:0], new_mac[79:32]
    input  logic        i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata   // hit[0], found_mac[48:1], stored[49], zero[55:50]
);
    import arpc_pkg::*;

    logic                   r_busy;
    t_req                   r_req;
    logic                   r_out_valid;
    t_res                   r_out;
    logic                   w_accept;
    logic                   w_hold;
    logic                   w_full;
    logic                   w_done;
    t_res                   w_res;
    logic [TABLE_ENTRIES:0] w_tok;
    t_res                   w_cell_res [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_done_vec;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_hold     = r_out_valid && !i_m_tready;
    assign o_s_tready = !r_busy;
    assign w_tok[0]   = w_accept;
    assign w_full     = w_tok[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            arpc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_hold  (w_hold),
                .i_tok   (w_tok[g]),
                .i_req   (r_req),
                .o_tok   (w_tok[g+1]),
                .o_res   (w_cell_res[g])
            );
            assign w_done_vec[g] = w_cell_res[g].done;
        end
    endgenerate

    always_comb begin
        w_res = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_res = w_res | w_cell_res[i];
        end
        w_done = w_res.done || w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.func <= i_s_tuser;
            r_req.ip   <= i_s_tdata[31:0];
            r_req.mac  <= i_s_tdata[79:32];
        end
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.stored, r_out.mac, r_out.hit};

    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_full, w_done_vec}))
        else $error("more than one cell resolved the same probe");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy)
        else $error("result produced with no word in the table");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote a pending output word");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.stored))
        else $error("result flagged both hit and stored");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted word did not start a probe");

endmodule

// ----- design/arpc_cell.sv -----
`timescale 1ns / 1ps

module arpc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic           i_tok,
    input  arpc_pkg::t_req i_req,
    output logic           o_tok,
    output arpc_pkg::t_res o_res
);
    import arpc_pkg::*;

    logic        r_tok;
    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        n_tok;
    logic        w_match;
    logic        w_act;
    logic        w_resolve;
    logic        w_write;

    // The probe stops here on a free entry or a matching one; free entries
    // only follow the valid ones, so a free entry also ends a lookup.
    always_comb begin
        w_match   = r_valid && (r_ip == i_req.ip);
        w_act     = r_tok && !i_hold;
        w_resolve = !r_valid || w_match;
        w_write   = w_act && w_resolve && (i_req.func == FUNC_ADD);
        n_tok     = (r_tok && i_hold) || i_tok;
        o_tok     = w_act && !w_resolve;

        o_res.done   = w_act && w_resolve;
        o_res.hit    = w_act && w_match && (i_req.func == FUNC_LOOKUP);
        o_res.mac    = o_res.hit ? r_mac : 48'd0;
        o_res.stored = w_write;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_ip  <= i_req.ip;
            r_mac <= i_req.mac;
        end
    end

endmodule

// ----- verif/arp_cache_table_tb.sv -----
`timescale 1ns / 1ps

module arp_cache_table_tb;

    import arpc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_WORDS = 450;
    localparam int MAX_PRINTS   = 60;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac;
        logic        stored;
    } t_arp_answer;

    typedef struct packed {
        logic        op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        is_typed;
        t_arp_answer answer;
    } t_lookup_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = FUNC_ADD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    logic        s_is_typed = 1'b0;
    t_arp_answer s_typed_ans = '0;

    logic        cache_valid [TABLE_ENTRIES] = '{default: 1'b0};
    logic [31:0] cache_ip    [TABLE_ENTRIES];
    logic [47:0] cache_mac   [TABLE_ENTRIES];

    t_arp_answer answer_q [$];
    logic [31:0] ip_pool [POOL_SIZE];

    int err_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    t_lookup_row dir_rows [0:20] = '{
        '{FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 1'b0}},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
        '{FUNC_ADD,    32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b1}},
        '{FUNC_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 1'b1}},
        '{FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b1, 48'h0, 1'b0}},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 1'b0}},
        '{FUNC_ADD,    32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b1, '{1'b0, 48'h0, 1'b1}},
        '{FUNC_ADD,    32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, '{1'b0, 48'h0, 1'b1}},
        '{FUNC_LOOKUP, 32'hAAAA_AAAA, 48'h0000_0000_0000, 1'b0, '0},
        '{FUNC_LOOKUP, 32'h5555_5555, 48'h0000_0000_0000, 1'b0, '0},
        '{FUNC_ADD,    32'h0000_0000, 48'h0123_4567_89AB, 1'b0, '0},
        '{FUNC_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 1'b0, '0},
        '{FUNC_ADD,    32'hFFFF_FFFF, 48'h0000_0000_0001, 1'b0, '0},
        '{FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0, '0},
        '{FUNC_LOOKUP, 32'h0A00_0001, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
        '{FUNC_LOOKUP, 32'hFFFF_FFFE, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
        '{FUNC_ADD,    32'hAAAA_AAAA, 48'h8000_0000_0000, 1'b0, '0},
        '{FUNC_LOOKUP, 32'hAAAA_AAAA, 48'h0000_0000_0000, 1'b0, '0},
        '{FUNC_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
        '{FUNC_ADD,    32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0, '0},
        '{FUNC_LOOKUP, 32'h7FFF_FFFF, 48'h0000_0000_0000, 1'b0, '0}
    };

    arp_cache_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // key_ip[31:0], new_mac[79:32]
        .i_s_tuser  (s_tuser),   // func[0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)    // hit[0], found_mac[48:1], stored[49], zero[55:50]
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("arp_cache_table_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    function automatic t_arp_answer resolve_arp(input logic op, input logic [31:0] ip,
                                                input logic [47:0] mac);
        t_arp_answer ans;
        ans = '0;
        if (op == FUNC_ADD) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!cache_valid[i] || cache_ip[i] == ip) begin
                    cache_valid[i] = 1'b1;
                    cache_ip[i]    = ip;
                    cache_mac[i]   = mac;
                    ans.stored     = 1'b1;
                    break;
                end
            end
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (cache_valid[i] && cache_ip[i] == ip) begin
                    ans.hit = 1'b1;
                    ans.mac = cache_mac[i];
                    break;
                end
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
        end
        err_count++;
    endtask

    always @(posedge clk) begin
        t_arp_answer want;
        if (rst_n) begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("word with nothing pending", {8'h0, m_tdata}, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        report_mismatch("hit", 64'(m_tdata[0]), 64'(want.hit));
                    end
                    if (m_tdata[48:1] !== want.mac) begin
                        report_mismatch("found_mac", 64'(m_tdata[48:1]), 64'(want.mac));
                    end
                    if (m_tdata[49] !== want.stored) begin
                        report_mismatch("stored", 64'(m_tdata[49]), 64'(want.stored));
                    end
                    if (m_tdata[55:50] !== 6'h0) begin
                        report_mismatch("padding", 64'(m_tdata[55:50]), 64'(6'h0));
                    end
                end
            end
            if (s_tvalid && s_tready === 1'b1) begin
                want = resolve_arp(s_tuser, s_tdata[31:0], s_tdata[79:32]);
                if (s_is_typed) begin
                    want = s_typed_ans;
                end
                answer_q.push_back(want);
            end
        end
    end

    task automatic send_word(input logic op, input logic [31:0] ip, input logic [47:0] mac,
                             input logic is_typed, input t_arp_answer typed_ans);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= op;
        s_tdata     <= {mac, ip};
        s_is_typed  <= is_typed;
        s_typed_ans <= typed_ans;
        @(posedge clk);
        while (s_tready !== 1'b1) begin
            @(posedge clk);
        end
    endtask

    initial begin
        logic        op;
        logic [31:0] ip;
        logic [47:0] mac;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'hAAAA_AAAA;
        ip_pool[3] = 32'h5555_5555;
        for (int i = 4; i < POOL_SIZE; i++) begin
            ip_pool[i] = $urandom;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 6;
        dst_idle_pct = 73;
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].op, dir_rows[k].ip, dir_rows[k].mac,
                      dir_rows[k].is_typed, dir_rows[k].answer);
        end

        // The pool holds more addresses than the table, so it fills up early and
        // the rest of the run mixes replacements, hits, misses and dropped adds.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
            dst_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 6 : 0;
            repeat (RANDOM_WORDS) begin
                op  = $urandom_range(0, 1) ? FUNC_LOOKUP : FUNC_ADD;
                ip  = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : 32'($urandom);
                mac = {16'($urandom), 32'($urandom)};
                send_word(op, ip, mac, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (answer_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
        if (err_count == 0 && answer_q.size() == 0) begin
            $display("arp_cache_table_tb OK");
        end else begin
            $display("arp_cache_table_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/arpc_pkg.sv
design/arpc_cell.sv
design/arp_cache_table.sv
verif/arp_cache_table_tb.sv
